// ===== design/bfto_pkg.sv =====
// shared types, constants and font table for the bitmap font text overlay
// no dependencies; used by the front end, the queue user, the back end and the top level

package bfto_pkg;

  // default number of text slots
  localparam int MAX_CHARS_DEF = 32;

  // depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // coordinate and field widths
  localparam int COORD_W   = 12;
  localparam int CODE_W    = 6;
  localparam int SLOT_W    = 5;
  localparam int CHAN_W    = 8;
  localparam int SCALE_W   = 4;
  localparam int LEN_W     = 6;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // quotient bits of the character index divider (text_length is at most 63)
  localparam int CHAR_IDX_W = 6;
  // quotient bits of the column and row dividers (values below 8)
  localparam int SUB_STEPS  = 3;

  // input commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DARKEN      = 3'd5;

  // glyph numbers
  localparam int GLYPH_COUNT = 39;
  localparam logic [CODE_W-1:0] GLYPH_LETTER_A = 6'd0;
  localparam logic [CODE_W-1:0] GLYPH_DIGIT_0  = 6'd26;
  localparam logic [CODE_W-1:0] GLYPH_SPACE    = 6'd36;
  localparam logic [CODE_W-1:0] GLYPH_COLON    = 6'd37;
  localparam logic [CODE_W-1:0] GLYPH_MINUS    = 6'd38;
  localparam logic [CODE_W-1:0] GLYPH_UNMAPPED = 6'd39;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [SCALE_W-1:0] glyph_scale;
    logic [LEN_W-1:0]   text_length;
    logic [COLOR_W-1:0] text_color;
    logic               darken_enable;
  } cfg_t;

  // classified item handed from front to back end
  typedef struct packed {
    logic               is_pix;
    logic [SLOT_W-1:0]  slot;
    logic [CODE_W-1:0]  code;
    logic               org_ok;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
  } q_entry_t;

  // 5x7 font, column-major: byte c holds font column c, bit 0 is the top row
  localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h00_1F_05_05_1F, 40'h00_0A_15_15_1F, 40'h00_11_11_11_0E, 40'h00_0E_11_11_1F,
    40'h00_11_15_15_1F, 40'h00_01_05_05_1F, 40'h00_1D_15_11_0E, 40'h00_1F_04_04_1F,
    40'h00_00_11_1F_11, 40'h00_0F_10_10_08, 40'h00_11_0A_04_1F, 40'h00_10_10_10_1F,
    40'h1F_02_04_02_1F, 40'h00_1F_04_02_1F, 40'h00_0E_11_11_0E, 40'h00_02_05_05_1F,
    40'h00_1E_19_11_0E, 40'h00_12_0D_05_1F, 40'h00_09_15_15_12, 40'h00_00_01_1F_01,
    40'h00_0F_10_10_0F, 40'h07_08_10_08_07, 40'h1F_08_04_08_1F, 40'h11_0A_04_0A_11,
    40'h01_02_1C_02_01, 40'h00_00_13_15_19, 40'h00_0E_11_11_0E, 40'h00_00_10_1F_12,
    40'h00_12_15_15_1A, 40'h00_0A_15_15_11, 40'h00_04_1F_04_07, 40'h00_09_15_15_17,
    40'h00_08_15_15_0E, 40'h00_03_1D_01_01, 40'h00_0A_15_15_0A, 40'h00_0E_15_15_02,
    40'h00_00_00_00_00, 40'h00_00_00_0A_00, 40'h00_00_04_04_04
  };

  // font columns of a glyph; unmapped codes draw nothing
  function automatic logic [39:0] font_columns(logic [CODE_W-1:0] code);
    logic [39:0] cols;
    cols = '0;
    if (code < CODE_W'(GLYPH_COUNT)) begin
      cols = FONT_ROM[code];
    end
    return cols;
  endfunction

endpackage

// ===== design/bfto_queue.sv =====
// small first-in first-out queue between the front and back end
// generic width and depth; no package dependencies

module bfto_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  // status
  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/bfto_front.sv =====
// front end: accepts input items, maps characters to glyphs, offsets pixels to the origin
// depends on bfto_pkg

module bfto_front (
  input  bfto_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [bfto_pkg::SLOT_W-1:0]       slot_i,
  input  logic [7:0]                        char_code_i,
  input  logic [bfto_pkg::COORD_W-1:0]      pixel_x_i,
  input  logic [bfto_pkg::COORD_W-1:0]      pixel_y_i,
  input  logic [bfto_pkg::CHAN_W-1:0]       in_blue_i,
  input  logic [bfto_pkg::CHAN_W-1:0]       in_green_i,
  input  logic [bfto_pkg::CHAN_W-1:0]       in_red_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output bfto_pkg::q_entry_t                q_data_o
);

  // ascii to glyph number, lower case folded to upper case
  function automatic logic [bfto_pkg::CODE_W-1:0] map_char(logic [7:0] ch);
    logic [7:0]                    up;
    logic [bfto_pkg::CODE_W-1:0]   code;
    up   = ch;
    code = bfto_pkg::GLYPH_UNMAPPED;
    if (ch >= "a" && ch <= "z") begin
      up = ch - 8'd32;
    end
    if (up >= "A" && up <= "Z") begin
      code = bfto_pkg::GLYPH_LETTER_A + 6'(up - "A");
    end else if (up >= "0" && up <= "9") begin
      code = bfto_pkg::GLYPH_DIGIT_0 + 6'(up - "0");
    end else if (up == " ") begin
      code = bfto_pkg::GLYPH_SPACE;
    end else if (up == ":") begin
      code = bfto_pkg::GLYPH_COLON;
    end else if (up == "-") begin
      code = bfto_pkg::GLYPH_MINUS;
    end
    return code;
  endfunction

  // transfer into the queue whenever it has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // classify the item
  always_comb begin
    q_data_o.is_pix = (command_i == bfto_pkg::CMD_PIXEL);
    q_data_o.slot   = slot_i;
    q_data_o.code   = map_char(char_code_i);
    q_data_o.org_ok = (pixel_x_i >= cfg_i.origin_x) && (pixel_y_i >= cfg_i.origin_y);
    q_data_o.dx     = pixel_x_i - cfg_i.origin_x;
    q_data_o.dy     = pixel_y_i - cfg_i.origin_y;
    q_data_o.blue   = in_blue_i;
    q_data_o.green  = in_green_i;
    q_data_o.red    = in_red_i;
  end

endmodule

// ===== design/bfto_back.sv =====
// back end: box test, character/column/row dividers, text store, font lookup and blend
// depends on bfto_pkg

module bfto_back #(
  parameter int MAX_CHARS = bfto_pkg::MAX_CHARS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfto_pkg::cfg_t               cfg_i,
  input  logic                         q_valid_i,
  input  bfto_pkg::q_entry_t           q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bfto_pkg::CHAN_W-1:0]  out_blue_o,
  output logic [bfto_pkg::CHAN_W-1:0]  out_green_o,
  output logic [bfto_pkg::CHAN_W-1:0]  out_red_o
);

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int QW = bfto_pkg::CHAR_IDX_W;
  localparam int SW = bfto_pkg::SUB_STEPS;

  typedef struct packed {
    logic                          valid;
    logic                          is_pix;
    logic                          in_box;
    logic [bfto_pkg::SLOT_W-1:0]   slot;
    logic [bfto_pkg::CODE_W-1:0]   code;
    logic [bfto_pkg::COORD_W-1:0]  rem;
    logic [QW-1:0]                 quo;
    logic [6:0]                    dy;
    logic [bfto_pkg::CHAN_W-1:0]   blue;
    logic [bfto_pkg::CHAN_W-1:0]   green;
    logic [bfto_pkg::CHAN_W-1:0]   red;
  } div_t;

  typedef struct packed {
    logic                          valid;
    logic                          is_pix;
    logic                          in_box;
    logic                          cx_ok;
    logic [6:0]                    colrem;
    logic [6:0]                    rowrem;
    logic [SW-1:0]                 col;
    logic [SW-1:0]                 row;
    logic [bfto_pkg::CODE_W-1:0]   code;
    logic [bfto_pkg::CHAN_W-1:0]   blue;
    logic [bfto_pkg::CHAN_W-1:0]   green;
    logic [bfto_pkg::CHAN_W-1:0]   red;
  } sub_t;

  // halve rounding half to even
  function automatic logic [7:0] halve_even(logic [7:0] p);
    return (p >> 1) + {7'd0, p[0] & p[1]};
  endfunction

  logic                         adv;
  logic [6:0]                   scale5, scale7, pitch;
  logic [bfto_pkg::LEN_W-1:0]   len_c;
  logic [12:0]                  box_w;
  logic [bfto_pkg::COORD_W-1:0] pitch_sh [QW];
  logic [6:0]                   scale_sh [SW];

  div_t div_q [QW+1];
  div_t div_d [QW+1];
  sub_t sub_q [SW+1];
  sub_t sub_d [SW+1];

  logic [bfto_pkg::CODE_W-1:0]  text_mem_q [MAX_CHARS];
  logic [bfto_pkg::CODE_W-1:0]  rd_q;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic                         wr_en;

  logic [63:0]                  glyph;
  logic                         lit;
  logic [7:0]                   bg_b, bg_g, bg_r;
  logic                         out_valid_q;
  logic [7:0]                   out_b_q, out_g_q, out_r_q;

  // whole pipeline moves unless a finished pixel waits on the output
  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  // geometry derived from the registers
  always_comb begin
    scale5 = {1'b0, cfg_i.glyph_scale, 2'b00} + {3'b000, cfg_i.glyph_scale};
    scale7 = {cfg_i.glyph_scale, 3'b000} - {3'b000, cfg_i.glyph_scale};
    pitch  = scale5 + 7'd1;
    if (32'(cfg_i.text_length) > MAX_CHARS) begin
      len_c = bfto_pkg::LEN_W'(MAX_CHARS);
    end else begin
      len_c = cfg_i.text_length;
    end
    box_w = 13'(len_c) * 13'(pitch);
    for (int k = 0; k < QW; k++) begin
      pitch_sh[k] = bfto_pkg::COORD_W'(pitch) << (QW - 1 - k);
    end
    for (int j = 0; j < SW; j++) begin
      scale_sh[j] = 7'(cfg_i.glyph_scale) << (SW - 1 - j);
    end
  end

  // box test and character index divider, one quotient bit per stage
  always_comb begin
    div_d[0].valid  = q_valid_i;
    div_d[0].is_pix = q_data_i.is_pix;
    div_d[0].in_box = q_data_i.is_pix && q_data_i.org_ok &&
                      ({1'b0, q_data_i.dx} < box_w) &&
                      (q_data_i.dy < bfto_pkg::COORD_W'(scale7));
    div_d[0].slot   = q_data_i.slot;
    div_d[0].code   = q_data_i.code;
    div_d[0].rem    = q_data_i.dx;
    div_d[0].quo    = '0;
    div_d[0].dy     = q_data_i.dy[6:0];
    div_d[0].blue   = q_data_i.blue;
    div_d[0].green  = q_data_i.green;
    div_d[0].red    = q_data_i.red;
    for (int k = 0; k < QW; k++) begin
      div_d[k+1] = div_q[k];
      if (div_q[k].rem >= pitch_sh[k]) begin
        div_d[k+1].rem = div_q[k].rem - pitch_sh[k];
        div_d[k+1].quo = {div_q[k].quo[QW-2:0], 1'b1};
      end else begin
        div_d[k+1].quo = {div_q[k].quo[QW-2:0], 1'b0};
      end
    end
  end

  // column and row dividers run side by side with the text store read
  always_comb begin
    sub_d[0].valid  = div_q[QW].valid;
    sub_d[0].is_pix = div_q[QW].is_pix;
    sub_d[0].in_box = div_q[QW].in_box;
    sub_d[0].cx_ok  = (div_q[QW].rem[6:0] < scale5);
    sub_d[0].colrem = div_q[QW].rem[6:0];
    sub_d[0].rowrem = div_q[QW].dy;
    sub_d[0].col    = '0;
    sub_d[0].row    = '0;
    sub_d[0].code   = '0;
    sub_d[0].blue   = div_q[QW].blue;
    sub_d[0].green  = div_q[QW].green;
    sub_d[0].red    = div_q[QW].red;
    for (int j = 0; j < SW; j++) begin
      sub_d[j+1] = sub_q[j];
      if (sub_q[j].colrem >= scale_sh[j]) begin
        sub_d[j+1].colrem = sub_q[j].colrem - scale_sh[j];
        sub_d[j+1].col    = {sub_q[j].col[SW-2:0], 1'b1};
      end else begin
        sub_d[j+1].col    = {sub_q[j].col[SW-2:0], 1'b0};
      end
      if (sub_q[j].rowrem >= scale_sh[j]) begin
        sub_d[j+1].rowrem = sub_q[j].rowrem - scale_sh[j];
        sub_d[j+1].row    = {sub_q[j].row[SW-2:0], 1'b1};
      end else begin
        sub_d[j+1].row    = {sub_q[j].row[SW-2:0], 1'b0};
      end
    end
    // glyph number arrives from the store one stage in
    sub_d[1].code = rd_q;
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) begin
        div_q[k] <= '0;
      end
      for (int j = 0; j <= SW; j++) begin
        sub_q[j] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k <= QW; k++) begin
        div_q[k] <= div_d[k];
      end
      for (int j = 0; j <= SW; j++) begin
        sub_q[j] <= sub_d[j];
      end
    end
  end

  // text store: writes and reads happen at the same stage, so item order holds
  assign rd_addr = AW'(div_q[QW].quo);
  assign wr_addr = AW'(div_q[QW].slot);
  assign wr_en   = adv && div_q[QW].valid && !div_q[QW].is_pix &&
                   (32'(div_q[QW].slot) < MAX_CHARS);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      text_mem_q[wr_addr] <= div_q[QW].code;
    end
    if (adv) begin
      rd_q <= text_mem_q[rd_addr];
    end
  end

  // darken, font lookup and color select
  always_comb begin
    glyph = {24'd0, bfto_pkg::font_columns(sub_q[SW].code)};
    lit   = sub_q[SW].in_box && sub_q[SW].cx_ok && glyph[{sub_q[SW].col, sub_q[SW].row}];
    bg_b  = sub_q[SW].blue;
    bg_g  = sub_q[SW].green;
    bg_r  = sub_q[SW].red;
    if (sub_q[SW].in_box && cfg_i.darken_enable) begin
      bg_b = halve_even(sub_q[SW].blue);
      bg_g = halve_even(sub_q[SW].green);
      bg_r = halve_even(sub_q[SW].red);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sub_q[SW].valid && sub_q[SW].is_pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_b_q <= lit ? cfg_i.text_color[7:0]   : bg_b;
      out_g_q <= lit ? cfg_i.text_color[15:8]  : bg_g;
      out_r_q <= lit ? cfg_i.text_color[23:16] : bg_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_blue_o  = out_b_q;
  assign out_green_o = out_g_q;
  assign out_red_o   = out_r_q;

`ifndef SYNTHESIS
  // character index of a boxed pixel falls inside the text
  a_char_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q[QW].valid && div_q[QW].in_box |-> (div_q[QW].quo < len_c))
    else $error("character index beyond text length");

  // divider remainder is a column offset within one pitch
  a_char_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q[QW].valid && div_q[QW].in_box |-> (div_q[QW].rem < bfto_pkg::COORD_W'(pitch)))
    else $error("character divider remainder not below pitch");

  // font position inside the 5x7 cell for a drawable pixel
  a_font_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q[SW].valid && sub_q[SW].in_box && sub_q[SW].cx_ok |->
      (sub_q[SW].col < 3'd5) && (sub_q[SW].row < 3'd7))
    else $error("font column or row out of range");

  // a result only ever follows a pixel item
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(sub_q[SW].valid && sub_q[SW].is_pix))
    else $error("result without a pixel item");
`endif

endmodule

// ===== design/bitmap_font_text_overlay.sv =====
// top level of the bitmap font text overlay: configuration registers, front end, queue, back end
// depends on bfto_pkg, bfto_front, bfto_queue and bfto_back
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+-----------------------------------
//   in       | input     | in_valid_i / in_stall_o     | command, slot, char_code, pixel, rgb
//   out      | output    | out_valid_o / out_stall_i   | out_blue, out_green, out_red
//   cfg      | input     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// While out_stall_i is low, one item per clock is accepted and one pixel result per clock
// is delivered. A pixel result passes through the queue entry, the box test register,
// six stages of the character index divider, the text store read, three stages of the
// column/row divider and the output register.
// The back pipeline moves as one unit and halts only while a result waits on a stalled output;
// the 4-entry queue then fills before in_stall_o rises.
// Reset clears the registers to their defaults and empties the pipeline; the text store is not
// cleared and reads of unwritten slots are undefined.

module bitmap_font_text_overlay #(
  parameter int MAX_CHARS = bfto_pkg::MAX_CHARS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [bfto_pkg::SLOT_W-1:0]       slot_i,
  input  logic [7:0]                        char_code_i,
  input  logic [bfto_pkg::COORD_W-1:0]      pixel_x_i,
  input  logic [bfto_pkg::COORD_W-1:0]      pixel_y_i,
  input  logic [bfto_pkg::CHAN_W-1:0]       in_blue_i,
  input  logic [bfto_pkg::CHAN_W-1:0]       in_green_i,
  input  logic [bfto_pkg::CHAN_W-1:0]       in_red_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bfto_pkg::CHAN_W-1:0]       out_blue_o,
  output logic [bfto_pkg::CHAN_W-1:0]       out_green_o,
  output logic [bfto_pkg::CHAN_W-1:0]       out_red_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bfto_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bfto_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int QEW = $bits(bfto_pkg::q_entry_t);

  bfto_pkg::cfg_t     cfg_q;
  bfto_pkg::q_entry_t push_data, pop_data;
  logic               push, pop, q_full, q_valid;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.glyph_scale   <= 4'd1;
      cfg_q.text_length   <= '0;
      cfg_q.text_color    <= 24'hFF_FFFF;
      cfg_q.darken_enable <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bfto_pkg::CFG_ORIGIN_X:    cfg_q.origin_x      <= cfg_data_i[11:0];
        bfto_pkg::CFG_ORIGIN_Y:    cfg_q.origin_y      <= cfg_data_i[11:0];
        bfto_pkg::CFG_GLYPH_SCALE: cfg_q.glyph_scale   <= cfg_data_i[3:0];
        bfto_pkg::CFG_TEXT_LENGTH: cfg_q.text_length   <= cfg_data_i[5:0];
        bfto_pkg::CFG_TEXT_COLOR:  cfg_q.text_color    <= cfg_data_i[23:0];
        bfto_pkg::CFG_DARKEN:      cfg_q.darken_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // classify incoming items
  bfto_front u_front (
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .slot_i      (slot_i),
    .char_code_i (char_code_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .in_blue_i   (in_blue_i),
    .in_green_i  (in_green_i),
    .in_red_i    (in_red_i),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_data_o    (push_data)
  );

  // decoupling queue
  bfto_queue #(
    .WIDTH (QEW),
    .DEPTH (bfto_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_data)
  );

  // overlay pipeline
  bfto_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o)
  );

endmodule
